// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the Spritz sponge block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define SPZ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define SPZ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/spz_pkg.sv =====
// ----------------------------------------------------------------------------
// spz_pkg
// Types, sizes and command codes shared by the Spritz sponge block.
// ----------------------------------------------------------------------------
`default_nettype none

package spz_pkg;

    // Permutation geometry.
    localparam int PERM_DEPTH = 256;
    localparam int ADDR_W     = $clog2(PERM_DEPTH);
    localparam int DATA_W     = 8;
    localparam int HALF_SIZE  = PERM_DEPTH / 2;
    localparam int HALF_W     = ADDR_W - 1;
    localparam int WHIP_STEPS = PERM_DEPTH * 2;
    localparam int CNT_W      = $clog2(WHIP_STEPS);

    // Shuffle is whip, crush, whip, crush, whip.
    localparam int PHASE_W    = 3;
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(4);

    // Command codes carried on tuser.
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_RESET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ABSORB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DRIP   = 2'd3;

    typedef logic [DATA_W-1:0] byte_t;
    typedef logic [CMD_W-1:0]  cmd_t;

endpackage

`default_nettype wire

// ===== src/spritz_sponge_cipher.sv =====
// The reset command runs a sweep that writes the identity into the permutation.
// A shuffle, when due, adds 1,536 updates of five states each (U0 to U4).
// Every cycle costs one access on the single-port permutation RAM; one item at a time.
// After rst_n rises, a clearing pass writes all 256 entries before the first input transfer.
// ----------------------------------------------------------------------------
// spritz_sponge_cipher
// Spritz sponge (N = 256) with absorb, absorb-stop, drip and reset commands,
// run by a small sequencer around one shared adder and one RAM port.
// ----------------------------------------------------------------------------
`default_nettype none

module spritz_sponge_cipher (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire spz_pkg::byte_t   s_axis_tdata,   // [7:0] data_byte
    input  wire spz_pkg::cmd_t    s_axis_tuser,   // [1:0] cmd
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output spz_pkg::byte_t        m_axis_tdata    // [7:0] out_byte
);

    import spz_pkg::*;

    // Sequencer states.
    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
    localparam logic [ST_W-1:0] ST_CLR  = 5'd1;
    localparam logic [ST_W-1:0] ST_CHK  = 5'd2;
    localparam logic [ST_W-1:0] ST_U0   = 5'd3;
    localparam logic [ST_W-1:0] ST_U1   = 5'd4;
    localparam logic [ST_W-1:0] ST_U2   = 5'd5;
    localparam logic [ST_W-1:0] ST_U3   = 5'd6;
    localparam logic [ST_W-1:0] ST_U4   = 5'd7;
    localparam logic [ST_W-1:0] ST_D0   = 5'd8;
    localparam logic [ST_W-1:0] ST_D1   = 5'd9;
    localparam logic [ST_W-1:0] ST_D2   = 5'd10;
    localparam logic [ST_W-1:0] ST_D3   = 5'd11;
    localparam logic [ST_W-1:0] ST_N0   = 5'd12;
    localparam logic [ST_W-1:0] ST_N1   = 5'd13;
    localparam logic [ST_W-1:0] ST_N2   = 5'd14;
    localparam logic [ST_W-1:0] ST_N3   = 5'd15;
    localparam logic [ST_W-1:0] ST_C0   = 5'd16;
    localparam logic [ST_W-1:0] ST_C1   = 5'd17;
    localparam logic [ST_W-1:0] ST_C2   = 5'd18;
    localparam logic [ST_W-1:0] ST_C3   = 5'd19;
    localparam logic [ST_W-1:0] ST_DONE = 5'd20;

    localparam logic [ADDR_W-1:0] HALF_ADDR  = ADDR_W'(HALF_SIZE);
    localparam logic [CNT_W-1:0]  WHIP_LAST  = CNT_W'(WHIP_STEPS - 1);
    localparam logic [HALF_W-1:0] CRUSH_LAST = HALF_W'(HALF_SIZE - 1);
    localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(PERM_DEPTH - 1);

    // Control state.
    logic [ST_W-1:0]    state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               drip_mode_reg, drip_mode_next;
    logic               nib_hi_reg, nib_hi_next;
    logic               cmd_pend_reg, cmd_pend_next;
    logic               out_valid_reg, out_valid_next;
    byte_t              idx_i_reg, idx_i_next;
    byte_t              idx_j_reg, idx_j_next;
    byte_t              idx_k_reg, idx_k_next;
    byte_t              last_out_reg, last_out_next;
    byte_t              absorb_pos_reg, absorb_pos_next;
    byte_t              step_w_reg, step_w_next;

    // Payload.
    cmd_t               cmd_reg, cmd_next;
    byte_t              data_reg, data_next;
    byte_t              tmp_reg, tmp_next;
    byte_t              res_reg, res_next;
    byte_t              out_data_reg, out_data_next;

    // RAM port and shared adder.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    byte_t              ram_wdata;
    byte_t              ram_rdata;
    byte_t              alu_a, alu_b, alu_c, alu_sum;

    logic               in_xfer;
    logic [3:0]         nibble;
    logic [ADDR_W-1:0]  crush_lo;

    spz_ram #(
        .Width (DATA_W),
        .Depth (PERM_DEPTH)
    ) u_spz_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign alu_sum  = alu_a + alu_b + alu_c;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign nibble   = nib_hi_reg ? data_reg[7:4] : data_reg[3:0];
    assign crush_lo = {1'b0, cnt_reg[HALF_W-1:0]};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Sequencer: each state issues one RAM access and at most one add.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        drip_mode_next  = drip_mode_reg;
        nib_hi_next     = nib_hi_reg;
        cmd_pend_next   = cmd_pend_reg;
        out_valid_next  = out_valid_reg;
        idx_i_next      = idx_i_reg;
        idx_j_next      = idx_j_reg;
        idx_k_next      = idx_k_reg;
        last_out_next   = last_out_reg;
        absorb_pos_next = absorb_pos_reg;
        step_w_next     = step_w_reg;
        cmd_next        = cmd_reg;
        data_next       = data_reg;
        tmp_next        = tmp_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_addr        = cnt_reg[ADDR_W-1:0];
        ram_wdata       = tmp_reg;
        alu_a           = idx_i_reg;
        alu_b           = step_w_reg;
        alu_c           = '0;

        // The consumer takes the waiting result.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next    = s_axis_tuser;
                    data_next   = s_axis_tdata;
                    nib_hi_next = 1'b0;
                    if (s_axis_tuser == CMD_RESET)
                    begin
                        idx_i_next      = '0;
                        idx_j_next      = '0;
                        idx_k_next      = '0;
                        last_out_next   = '0;
                        absorb_pos_next = '0;
                        step_w_next     = 8'd1;
                        cnt_next        = '0;
                        cmd_pend_next   = 1'b1;
                        state_next      = ST_CLR;
                    end
                    else
                    begin
                        state_next = ST_CHK;
                    end
                end
            end

            // Write the identity permutation, one entry per cycle.
            ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg[ADDR_W-1:0];
                ram_wdata = cnt_reg[ADDR_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[ADDR_W-1:0] == CLR_LAST)
                begin
                    res_next   = '0;
                    state_next = cmd_pend_reg ? ST_DONE : ST_IDLE;
                end
            end

            // Decide whether a shuffle is due before the command proper.
            ST_CHK:
            begin
                case (cmd_reg)
                    CMD_ABSORB:
                    begin
                        if (absorb_pos_reg == HALF_ADDR)
                        begin
                            phase_next     = '0;
                            cnt_next       = '0;
                            drip_mode_next = 1'b0;
                            state_next     = ST_U0;
                        end
                        else
                        begin
                            state_next = ST_N0;
                        end
                    end
                    CMD_STOP:
                    begin
                        if (absorb_pos_reg == HALF_ADDR)
                        begin
                            phase_next     = '0;
                            cnt_next       = '0;
                            drip_mode_next = 1'b0;
                            state_next     = ST_U0;
                        end
                        else
                        begin
                            absorb_pos_next = absorb_pos_reg + 1'b1;
                            res_next        = '0;
                            state_next      = ST_DONE;
                        end
                    end
                    CMD_DRIP:
                    begin
                        if (absorb_pos_reg != '0)
                        begin
                            phase_next     = '0;
                            cnt_next       = '0;
                            drip_mode_next = 1'b0;
                        end
                        else
                        begin
                            drip_mode_next = 1'b1;
                        end
                        state_next = ST_U0;
                    end
                    default:
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                endcase
            end

            // Update step: i += w, read perm[i].
            ST_U0:
            begin
                alu_a      = idx_i_reg;
                alu_b      = step_w_reg;
                ram_addr   = alu_sum;
                idx_i_next = alu_sum;
                state_next = ST_U1;
            end

            // Keep perm[i], read perm[j + perm[i]].
            ST_U1:
            begin
                tmp_next   = ram_rdata;
                alu_a      = idx_j_reg;
                alu_b      = ram_rdata;
                ram_addr   = alu_sum;
                state_next = ST_U2;
            end

            // New j, read perm[j].
            ST_U2:
            begin
                alu_a      = idx_k_reg;
                alu_b      = ram_rdata;
                idx_j_next = alu_sum;
                ram_addr   = alu_sum;
                state_next = ST_U3;
            end

            // New k, first half of the swap: perm[i] = perm[j].
            ST_U3:
            begin
                alu_a      = idx_i_reg;
                alu_b      = idx_k_reg;
                alu_c      = ram_rdata;
                idx_k_next = alu_sum;
                ram_we     = 1'b1;
                ram_addr   = idx_i_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_U4;
            end

            // Second half of the swap, then pick the next step.
            ST_U4:
            begin
                ram_we    = 1'b1;
                ram_addr  = idx_j_reg;
                ram_wdata = tmp_reg;
                if (drip_mode_reg)
                begin
                    state_next = ST_D0;
                end
                else if (cnt_reg == WHIP_LAST)
                begin
                    step_w_next = step_w_reg + 8'd2;
                    cnt_next    = '0;
                    if (phase_reg == LAST_PHASE)
                    begin
                        absorb_pos_next = '0;
                        state_next      = ST_CHK;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                        state_next = ST_C0;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_U0;
                end
            end

            // Output lookups: z + k, then i + t, then j + t.
            ST_D0:
            begin
                alu_a      = last_out_reg;
                alu_b      = idx_k_reg;
                ram_addr   = alu_sum;
                state_next = ST_D1;
            end

            ST_D1:
            begin
                alu_a      = idx_i_reg;
                alu_b      = ram_rdata;
                ram_addr   = alu_sum;
                state_next = ST_D2;
            end

            ST_D2:
            begin
                alu_a      = idx_j_reg;
                alu_b      = ram_rdata;
                ram_addr   = alu_sum;
                state_next = ST_D3;
            end

            ST_D3:
            begin
                last_out_next  = ram_rdata;
                res_next       = data_reg ^ ram_rdata;
                drip_mode_next = 1'b0;
                state_next     = ST_DONE;
            end

            // Absorb one nibble: swap perm[a] with perm[128 + nibble].
            ST_N0:
            begin
                ram_addr   = absorb_pos_reg;
                state_next = ST_N1;
            end

            ST_N1:
            begin
                tmp_next   = ram_rdata;
                alu_a      = HALF_ADDR;
                alu_b      = {4'h0, nibble};
                ram_addr   = alu_sum;
                state_next = ST_N2;
            end

            ST_N2:
            begin
                ram_we     = 1'b1;
                ram_addr   = absorb_pos_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_N3;
            end

            ST_N3:
            begin
                alu_a           = HALF_ADDR;
                alu_b           = {4'h0, nibble};
                ram_we          = 1'b1;
                ram_addr        = alu_sum;
                ram_wdata       = tmp_reg;
                absorb_pos_next = absorb_pos_reg + 1'b1;
                if (!nib_hi_reg)
                begin
                    nib_hi_next = 1'b1;
                    state_next  = ST_CHK;
                end
                else
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
            end

            // Crush: order the pair (perm[v], perm[255 - v]).
            ST_C0:
            begin
                ram_addr   = crush_lo;
                state_next = ST_C1;
            end

            ST_C1:
            begin
                tmp_next   = ram_rdata;
                ram_addr   = ~crush_lo;
                state_next = ST_C2;
            end

            ST_C2:
            begin
                if (tmp_reg > ram_rdata)
                begin
                    ram_we     = 1'b1;
                    ram_addr   = crush_lo;
                    ram_wdata  = ram_rdata;
                    state_next = ST_C3;
                end
                else if (cnt_reg[HALF_W-1:0] == CRUSH_LAST)
                begin
                    phase_next = phase_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = ST_U0;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_C0;
                end
            end

            ST_C3:
            begin
                ram_we    = 1'b1;
                ram_addr  = ~crush_lo;
                ram_wdata = tmp_reg;
                if (cnt_reg[HALF_W-1:0] == CRUSH_LAST)
                begin
                    phase_next = phase_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = ST_U0;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_C0;
                end
            end

            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    cmd_pend_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            cnt_reg        <= '0;
            phase_reg      <= '0;
            drip_mode_reg  <= 1'b0;
            nib_hi_reg     <= 1'b0;
            cmd_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_i_reg      <= '0;
            idx_j_reg      <= '0;
            idx_k_reg      <= '0;
            last_out_reg   <= '0;
            absorb_pos_reg <= '0;
            step_w_reg     <= 8'd1;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            phase_reg      <= phase_next;
            drip_mode_reg  <= drip_mode_next;
            nib_hi_reg     <= nib_hi_next;
            cmd_pend_reg   <= cmd_pend_next;
            out_valid_reg  <= out_valid_next;
            idx_i_reg      <= idx_i_next;
            idx_j_reg      <= idx_j_next;
            idx_k_reg      <= idx_k_next;
            last_out_reg   <= last_out_next;
            absorb_pos_reg <= absorb_pos_next;
            step_w_reg     <= step_w_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        data_reg     <= data_next;
        tmp_reg      <= tmp_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== src/spz_ram.sv =====
// ----------------------------------------------------------------------------
// spz_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spz_ram #(
    parameter int Width = spz_pkg::DATA_W,
    parameter int Depth = spz_pkg::PERM_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    // One access per cycle: a write, or a read that lands next cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/spz_checker.sv =====
// ----------------------------------------------------------------------------
// spz_checker
// Port-level checks on the Spritz sponge block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spz_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           s_axis_tvalid,
    input wire logic           s_axis_tready,
    input wire spz_pkg::byte_t s_axis_tdata,   // [7:0] data_byte
    input wire spz_pkg::cmd_t  s_axis_tuser,   // [1:0] cmd
    input wire logic           m_axis_tvalid,
    input wire logic           m_axis_tready,
    input wire spz_pkg::byte_t m_axis_tdata    // [7:0] out_byte
);

    import spz_pkg::*;

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] pend_cnt_reg;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Items taken in but whose result has not yet been transferred out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= '0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    `SPZ_ASSERT_RST(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "stalled result changed")

    `SPZ_ASSERT_RST(a_busy_after_in, clk, rst_n,
        in_xfer |=> !s_axis_tready,
        "block ready again right after an input transfer")

    `SPZ_ASSERT_RST(a_result_from_work, clk, rst_n,
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready),
        "result appeared while the block was idle")

    `SPZ_ASSERT_RST(a_no_extra_result, clk, rst_n,
        m_axis_tvalid |-> pend_cnt_reg != 2'd0 && (s_axis_tdata == s_axis_tdata),
        "result without a matching input transfer")

    `SPZ_ASSERT_ALWAYS(a_reset_quiet, clk,
        !rst_n |-> !m_axis_tvalid && (s_axis_tuser == s_axis_tuser),
        "result valid during reset")

endmodule

bind spritz_sponge_cipher spz_checker u_spz_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
